>>> design/nlms_pkg.sv
// Shared widths, formats and register indexes of the NLMS echo canceller.
// Used by the multiplier, the divider and the top-level core.
package nlms_pkg;

    // Sample and weight formats.
    localparam int SAMPLE_BITS = 16;
    localparam int WEIGHT_BITS = 32;
    localparam int WEIGHT_FRAC = 27;
    localparam int TAPS_DEF    = 256;

    // Gain: floor(mu*|err|*2^26 / den), clamped to 47 bits.
    localparam int STEP_BITS  = 16;
    localparam int REG_BITS   = 32;
    localparam int GAIN_SHIFT = 26;
    localparam int GAIN_BITS  = 47;
    localparam int NUM_W      = STEP_BITS + SAMPLE_BITS + GAIN_SHIFT;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = GAIN_BITS + 1;
    localparam int MUL_B_W = SAMPLE_BITS + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration register indexes and reset values.
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REGULARIZATION = 1'b1;
    localparam logic [STEP_BITS-1:0]  STEP_RST = 16'd32768;
    localparam logic [REG_BITS-1:0]   REGZ_RST = 32'd1024;

endpackage

>>> design/nlms_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nlms_pkg for operand widths.
module nlms_mul
    import nlms_pkg::*;
(
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p_reg
);

    // One product per enabled cycle.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

endmodule

>>> design/nlms_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nlms_pkg for the numerator width.
module nlms_div
    import nlms_pkg::*;
#(
    parameter int DEN_W = 41
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Trial subtraction of the divisor from the shifted remainder.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    // Control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> design/nlms_echo_canceller_with_freeze_core.sv
// NLMS echo canceller with adaptation hold: sequencer, window and weight memories.
// Depends on nlms_pkg, nlms_mul and nlms_div.
// After reset the block clears its two memories and takes no word until it is done.
// Each word is then worked through before the next is taken: one shared multiplier runs
// the energy update, the dot product, the gain product and the weight update, and a
// one-bit-per-cycle divider computes the gain (58 quotient bits, then a done strobe). With
// hold set the gain product, divide and weight update are skipped. A full output register
// holds the sequencer in the output step until m_tready.
// The result word sits in an output register, so the update runs while it waits.
module nlms_echo_canceller_with_freeze_core
    import nlms_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,   // mic_sample [15:0], ref_sample [31:16]
    input  logic                    s_tuser,   // hold_adaptation [0]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [15:0]             m_tdata,   // error_sample [15:0]
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [REG_BITS-1:0]     cfg_wdata
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW    = $clog2(TAPS + 1);
    localparam int ENW   = 32 + $clog2(TAPS);
    localparam int DEN_W = ENW + 1;
    localparam int ACC_W = 48 + $clog2(TAPS);
    localparam int EF_W  = ACC_W + 2;
    localparam int WS_W  = GAIN_BITS + 3;
    localparam logic signed [EF_W-1:0] E_MAX = EF_W'(32767);
    localparam logic signed [EF_W-1:0] E_MIN = EF_W'(-32768);
    localparam logic signed [WS_W-1:0] W_MAX = WS_W'(64'sd2147483647);
    localparam logic signed [WS_W-1:0] W_MIN = WS_W'(-64'sd2147483648);
    localparam logic [63:0] EN_MAX = 64'(TAPS) << 30;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_LEAVE = 10'b0000000100,
        S_ENUPD = 10'b0000001000,
        S_MAC   = 10'b0000010000,
        S_ERR   = 10'b0000100000,
        S_PUT   = 10'b0001000000,
        S_GAIN  = 10'b0010000000,
        S_DIVGO = 10'b0100000000,
        S_DIV   = 10'b1000000000
    } state_t;

    // The weight update is a flag beside the state; it reuses the stream counter of
    // the dot product and runs while the sequencer sits in the idle state.
    logic upd_reg;

    state_t state_reg, state_next;

    logic [AW-1:0]  clr_cnt_reg;
    logic [AW-1:0]  head_reg;
    logic [AW-1:0]  rp_reg;
    logic [AW-1:0]  hn;
    logic [CW-1:0]  cnt_reg;
    logic           v1_reg, v2_reg;
    logic [AW-1:0]  addr1_reg, addr2_reg;
    logic signed [WEIGHT_BITS-1:0] w2_reg;
    logic           neg2_reg;
    logic signed [SAMPLE_BITS-1:0] mic_reg, ref_reg;
    logic           hold_reg;
    logic [ENW-1:0] energy_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SAMPLE_BITS-1:0] err_reg;
    logic [GAIN_BITS-1:0] q_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [REG_BITS-1:0]  regz_reg;
    logic           m_tvalid_reg;
    logic [15:0]    m_tdata_reg;

    // Memories.
    logic signed [SAMPLE_BITS-1:0] win_mem [TAPS];
    logic signed [WEIGHT_BITS-1:0] wt_mem [TAPS];
    logic signed [SAMPLE_BITS-1:0] win_rd_reg;
    logic signed [WEIGHT_BITS-1:0] wt_rd_reg;
    logic          win_we, wt_we;
    logic [AW-1:0] win_waddr, wt_waddr, win_raddr;
    logic signed [SAMPLE_BITS-1:0] win_wdata;
    logic signed [WEIGHT_BITS-1:0] wt_wdata;

    logic issue, in_acc, stream, stream_done;
    logic mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [SAMPLE_BITS:0] diff17, sum17;
    logic [SAMPLE_BITS-1:0] xmag, errmag;
    logic signed [EF_W-1:0] efull, esh;
    logic signed [SAMPLE_BITS-1:0] err_sat;
    logic [DEN_W-1:0] den_raw, den;
    logic div_start, div_done;
    logic [NUM_W-1:0] div_quo;
    logic [GAIN_BITS-1:0] q_sat;
    logic signed [WS_W-1:0] w_ext, d_ext, ws;
    logic signed [WEIGHT_BITS-1:0] w_new;

    assign in_acc      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == S_IDLE) && !upd_reg;
    assign stream      = (state_reg == S_MAC) || upd_reg;
    assign issue       = stream && (cnt_reg < CW'(TAPS));
    assign stream_done = (cnt_reg == CW'(TAPS)) && !v1_reg && !v2_reg;
    assign hn          = (head_reg == AW'(TAPS - 1)) ? '0 : head_reg + 1'b1;

    // Memory ports.
    assign win_raddr = stream ? rp_reg : head_reg;
    assign win_we    = (state_reg == S_CLEAR) || (state_reg == S_ENUPD);
    assign win_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : head_reg;
    assign win_wdata = (state_reg == S_CLEAR) ? '0 : ref_reg;
    assign wt_we     = (state_reg == S_CLEAR) || (upd_reg && v2_reg);
    assign wt_waddr  = (state_reg == S_CLEAR) ? clr_cnt_reg : addr2_reg;
    assign wt_wdata  = (state_reg == S_CLEAR) ? '0 : w_new;

    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[win_waddr] <= win_wdata;
        end
        win_rd_reg <= win_mem[win_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wt_we) begin
            wt_mem[wt_waddr] <= wt_wdata;
        end
        wt_rd_reg <= wt_mem[cnt_reg[AW-1:0]];
    end

    // Shared multiplier operand selection.
    assign diff17 = (SAMPLE_BITS + 1)'(ref_reg) - (SAMPLE_BITS + 1)'(win_rd_reg);
    assign sum17  = (SAMPLE_BITS + 1)'(ref_reg) + (SAMPLE_BITS + 1)'(win_rd_reg);
    assign xmag   = win_rd_reg[SAMPLE_BITS-1] ? (~win_rd_reg + 1'b1) : win_rd_reg;
    assign errmag = err_reg[SAMPLE_BITS-1] ? (~err_reg + 1'b1) : err_reg;

    always_comb begin
        mul_a = MUL_A_W'(wt_rd_reg);
        mul_b = MUL_B_W'(win_rd_reg);
        if (upd_reg) begin
            mul_a = {1'b0, q_reg};
            mul_b = {1'b0, xmag};
        end else if (state_reg == S_LEAVE) begin
            mul_a = MUL_A_W'(diff17);
            mul_b = sum17;
        end else if (state_reg == S_GAIN) begin
            mul_a = {{(MUL_A_W - STEP_BITS){1'b0}}, step_reg};
            mul_b = {1'b0, errmag};
        end
    end

    assign mul_en = (state_reg == S_LEAVE) || (state_reg == S_GAIN) || v1_reg;

    nlms_mul u_mul (
        .aclk  (aclk),
        .en    (mul_en),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    // Error: mic*2^27 minus prediction, rounded half up and saturated.
    assign efull = (EF_W'(mic_reg) <<< WEIGHT_FRAC) - EF_W'(acc_reg)
                   + (EF_W'(1) <<< (WEIGHT_FRAC - 1));
    assign esh   = efull >>> WEIGHT_FRAC;
    assign err_sat = (esh > E_MAX) ? SAMPLE_BITS'(E_MAX) :
                     (esh < E_MIN) ? SAMPLE_BITS'(E_MIN) : SAMPLE_BITS'(esh);

    // Gain divider; a zero denominator divides by one.
    assign den_raw   = DEN_W'(energy_reg) + DEN_W'(regz_reg);
    assign den       = (den_raw == '0) ? DEN_W'(1) : den_raw;
    assign div_start = (state_reg == S_DIVGO);

    nlms_div #(.DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({mul_p[STEP_BITS+SAMPLE_BITS-1:0], {GAIN_SHIFT{1'b0}}}),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign q_sat = (div_quo[NUM_W-1:GAIN_BITS] != '0) ? {GAIN_BITS{1'b1}}
                                                      : div_quo[GAIN_BITS-1:0];

    // Weight update: w + sign * floor(q*|x| / 2^15), saturated to 32 bits.
    assign w_ext = WS_W'(w2_reg);
    assign d_ext = {3'b000, mul_p[GAIN_BITS+SAMPLE_BITS-2:SAMPLE_BITS-1]};
    assign ws    = neg2_reg ? (w_ext - d_ext) : (w_ext + d_ext);
    assign w_new = (ws > W_MAX) ? WEIGHT_BITS'(W_MAX) :
                   (ws < W_MIN) ? WEIGHT_BITS'(W_MIN) : WEIGHT_BITS'(ws);

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_cnt_reg == AW'(TAPS - 1)) state_next = S_IDLE;
            S_IDLE:  if (in_acc) state_next = S_LEAVE;
            S_LEAVE: state_next = S_ENUPD;
            S_ENUPD: state_next = S_MAC;
            S_MAC:   if (stream_done) state_next = S_ERR;
            S_ERR:   state_next = S_PUT;
            S_PUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = hold_reg ? S_IDLE : S_GAIN;
                end
            end
            S_GAIN:  state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            upd_reg      <= 1'b0;
            clr_cnt_reg  <= '0;
            head_reg     <= '0;
            cnt_reg      <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            energy_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            step_reg     <= STEP_RST;
            regz_reg     <= REGZ_RST;
        end else begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == S_ENUPD) begin
                energy_reg <= energy_reg + mul_p[ENW-1:0];
                head_reg   <= hn;
                cnt_reg    <= '0;
            end
            if (issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            // The weight update runs in the idle state with input held off.
            if (state_reg == S_DIV && div_done) begin
                upd_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (upd_reg && stream_done) begin
                upd_reg <= 1'b0;
            end
            if (state_reg == S_PUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_STEP_SIZE:      step_reg <= cfg_wdata[STEP_BITS-1:0];
                    CFG_REGULARIZATION: regz_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            mic_reg  <= s_tdata[15:0];
            ref_reg  <= s_tdata[31:16];
            hold_reg <= s_tuser;
        end
        if (state_reg == S_ENUPD) begin
            rp_reg  <= hn;
            acc_reg <= '0;
        end else if (state_reg == S_DIV && div_done) begin
            rp_reg <= head_reg;
            q_reg  <= q_sat;
        end else if (issue) begin
            rp_reg <= (rp_reg == AW'(TAPS - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (state_reg == S_MAC && v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(mul_p);
        end
        addr1_reg <= cnt_reg[AW-1:0];
        addr2_reg <= addr1_reg;
        w2_reg    <= wt_rd_reg;
        neg2_reg  <= err_reg[SAMPLE_BITS-1] ^ win_rd_reg[SAMPLE_BITS-1];
        if (state_reg == S_ERR) begin
            err_reg <= err_sat;
        end
        if (state_reg == S_PUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // An accepted word closes the input until its work is done.
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("input accepted while a word is in work");

    // The window energy never exceeds TAPS full-scale squares.
    a_energy: assert property (@(posedge aclk) disable iff (!aresetn)
        {{(64 - ENW){1'b0}}, energy_reg} <= EN_MAX)
        else $error("window energy out of range");

    // A result appears only from the output step.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_PUT)
        else $error("result word not from output step");

    // The divider finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("unexpected divider completion");

    // The weight update never overlaps the dot product.
    a_upd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_reg |-> (state_reg == S_IDLE))
        else $error("weight update outside idle");
`endif

endmodule

>>> dv/nlms_echo_canceller_with_freeze_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the NLMS echo canceller core: a directed table, then random
// words, most under random idling on both stream sides. Depends on nlms_pkg and the core RTL.
module nlms_echo_canceller_with_freeze_core_tb;
    import nlms_pkg::*;

    localparam int TAPS = TAPS_DEF;
    localparam int SETTLE_CYCLES = 2 * TAPS + 400;
    localparam int EXP_DEPTH = 1024;
    localparam longint unsigned GAIN_LIMIT = (64'd1 << GAIN_BITS) - 1;

    typedef struct packed {
        logic [15:0] mic;
        logic [15:0] rf;
        logic        hold;
        logic        typed;
        logic [15:0] want;
    } stim_row_t;

    localparam int DIR_ROWS = 16;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // mic_sample [15:0], ref_sample [31:16]
    logic                  s_tuser;   // hold_adaptation [0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // error_sample [15:0]
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [REG_BITS-1:0]   cfg_wdata;

    // Predictor state: window is oldest first, so weight t pairs with echo_window[t].
    shortint               echo_window [TAPS];
    int                    tap_w [TAPS];
    longint unsigned       win_energy;
    logic [STEP_BITS-1:0]  mu_reg;
    logic [REG_BITS-1:0]   regz_reg;

    // Expected words in order; the sender writes at exp_wr, the checker reads at exp_rd.
    logic [15:0]           expected_errors [EXP_DEPTH];
    int                    exp_wr;
    int                    exp_rd;
    int                    mismatches;
    int                    words_sent;
    int                    words_checked;
    bit                    idling_on;
    bit                    long_holdoff;
    stim_row_t             dir_rows [DIR_ROWS];

    nlms_echo_canceller_with_freeze_core #(.TAPS(TAPS)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (word %0d)", what, got, want,
                 words_checked);
        mismatches++;
    endtask

    // Computes the error for one word and advances the predictor state.
    function automatic logic [15:0] predict_error(input shortint mic, input shortint rf,
                                                  input bit hold);
        shortint         leaving;
        longint          acc;
        longint          efull;
        longint          err;
        longint unsigned den;
        longint unsigned q;
        longint unsigned d_mag;
        longint          w;
        longint          x;
        leaving = echo_window[0];
        win_energy = win_energy + longint'(longint'(rf) * rf)
                     - longint'(longint'(leaving) * leaving);
        for (int t = 0; t < TAPS - 1; t++) echo_window[t] = echo_window[t + 1];
        echo_window[TAPS - 1] = rf;

        acc = 0;
        for (int t = 0; t < TAPS; t++) acc += longint'(tap_w[t]) * longint'(echo_window[t]);
        efull = (longint'(mic) <<< WEIGHT_FRAC) - acc;
        err = (efull + (64'sd1 <<< (WEIGHT_FRAC - 1))) >>> WEIGHT_FRAC;
        if (err > 32767) err = 32767;
        if (err < -32768) err = -32768;

        if (!hold) begin
            den = win_energy + longint'(regz_reg);
            if (den == 0) den = 1;
            q = ((longint'(mu_reg) * longint'(err < 0 ? -err : err)) << GAIN_SHIFT) / den;
            if (q > GAIN_LIMIT) q = GAIN_LIMIT;
            for (int t = 0; t < TAPS; t++) begin
                x = echo_window[t];
                d_mag = (q * longint'(x < 0 ? -x : x)) >> (SAMPLE_BITS - 1);
                w = ((err < 0) != (x < 0)) ? longint'(tap_w[t]) - longint'(d_mag)
                                           : longint'(tap_w[t]) + longint'(d_mag);
                if (w > 64'sd2147483647) w = 64'sd2147483647;
                if (w < -64'sd2147483648) w = -64'sd2147483648;
                tap_w[t] = int'(w);
            end
        end
        return err[15:0];
    endfunction

    // Offers one word and waits for it to be taken; valid stays high afterward.
    task automatic send_word(input logic [15:0] mic, input logic [15:0] rf, input bit hold,
                             input bit typed, input logic [15:0] want);
        logic [15:0] predicted;
        s_tdata  <= {rf, mic};
        s_tuser  <= hold;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_error(mic, rf, hold);
        expected_errors[exp_wr % EXP_DEPTH] = typed ? want : predicted;
        exp_wr++;
        words_sent++;
    endtask

    task automatic sender_gap();
        int n;
        n = $urandom_range(4, 1);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Waits for every expected word, then lets the background weight update finish.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [STEP_BITS-1:0] mu, input logic [REG_BITS-1:0] rz);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_STEP_SIZE;
        cfg_wdata <= REG_BITS'(mu);
        @(posedge aclk);
        cfg_addr  <= CFG_REGULARIZATION;
        cfg_wdata <= rz;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mu_reg   = mu;
        regz_reg = rz;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7, 0))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(8, 0)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random words: mostly an echo of the recent reference plus noise, some raw noise.
    task automatic random_phase(input int count);
        logic [15:0] rf;
        logic [15:0] mic;
        shortint     echo;
        for (int i = 0; i < count; i++) begin
            rf = pick_sample();
            if ($urandom_range(3, 0) != 0) begin
                echo = (echo_window[TAPS - 1] >>> 1) + (echo_window[TAPS - 3] >>> 2);
                mic = 16'(echo) + 16'($urandom_range(64, 0)) - 16'd32;
            end else begin
                mic = pick_sample();
            end
            send_word(mic, rf, $urandom_range(4, 0) == 0, 1'b0, 16'd0);
            if (idling_on && $urandom_range(3, 0) == 0) sender_gap();
        end
    endtask

    // Result side: check each taken word, then choose the next ready level.
    initial begin
        int stall_left;
        int long_left;
        logic [15:0] want;
        stall_left = 0;
        long_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (exp_wr == exp_rd) begin
                    report_mismatch("unexpected word", int'($signed(m_tdata)), 0);
                end else begin
                    want = expected_errors[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (m_tdata !== want)
                        report_mismatch("error_sample", int'($signed(m_tdata)),
                                        int'($signed(want)));
                end
                words_checked++;
            end
            if (long_holdoff && long_left == 0) begin
                long_left = 4000;
                long_holdoff = 1'b0;
            end
            if (long_left > 0) begin
                long_left--;
                m_tready <= 1'b0;
            end else if (idling_on && stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(5, 0) == 0) begin
                stall_left = $urandom_range(3, 0);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        // Rows before the first adaptive word with a nonzero window have zero weights, so
        // the error equals the mic sample; later rows are left to the predictor.
        dir_rows = '{
            '{16'd0,      16'd0,      1'b0, 1'b1, 16'd0},      // zero energy, no offset
            '{16'h7FFF,   16'd0,      1'b1, 1'b1, 16'h7FFF},
            '{16'h8000,   16'd0,      1'b1, 1'b1, 16'h8000},
            '{16'h7FFF,   16'd0,      1'b0, 1'b1, 16'h7FFF},   // gain clamps
            '{16'h8000,   16'd0,      1'b0, 1'b1, 16'h8000},
            '{16'd100,    16'd1,      1'b0, 1'b1, 16'd100},    // weights saturate high
            '{16'd0,      16'd0,      1'b0, 1'b0, 16'd0},
            '{16'h8000,   16'h8000,   1'b0, 1'b0, 16'd0},
            '{16'h7FFF,   16'h7FFF,   1'b1, 1'b0, 16'd0},
            '{16'd0,      16'hFFFF,   1'b0, 1'b0, 16'd0},
            '{16'h7FFF,   16'h8000,   1'b0, 1'b0, 16'd0},
            '{16'h8000,   16'h7FFF,   1'b0, 1'b0, 16'd0},
            '{16'h5555,   16'hAAAA,   1'b1, 1'b0, 16'd0},
            '{16'hAAAA,   16'h5555,   1'b0, 1'b0, 16'd0},
            '{16'd1,      16'hFFFF,   1'b0, 1'b0, 16'd0},
            '{16'hFFFF,   16'd1,      1'b1, 1'b0, 16'd0}
        };
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = CFG_STEP_SIZE;
        cfg_wdata = '0;
        idling_on = 1'b1;
        long_holdoff = 1'b0;
        exp_wr = 0;
        exp_rd = 0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        win_energy = 0;
        mu_reg = STEP_RST;
        regz_reg = REGZ_RST;
        for (int t = 0; t < TAPS; t++) begin
            echo_window[t] = 0;
            tap_w[t] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table at the largest step and no regularization.
        write_regs(16'hFFFF, 32'd0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].mic, dir_rows[i].rf, dir_rows[i].hold,
                      dir_rows[i].typed, dir_rows[i].want);
        drain_block();

        // Reset-value settings; the output side holds off while words keep coming.
        write_regs(STEP_RST, REGZ_RST);
        long_holdoff = 1'b1;
        random_phase(180);
        drain_block();

        // No adaptation step, largest regularization.
        write_regs(16'd0, 32'hFFFF_FFFF);
        random_phase(100);
        drain_block();

        // Moderate step, then the last stretch with no idling.
        write_regs(16'd1000, 32'h0010_0000);
        random_phase(140);
        idling_on = 1'b0;
        random_phase(120);
        drain_block();

        $display("Covered %0d words (%0d checked) over four register settings,", words_sent,
                 words_checked);
        $display("with hold, saturation, clamped gain and output back-pressure.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/nlms_pkg.sv
design/nlms_mul.sv
design/nlms_div.sv
design/nlms_echo_canceller_with_freeze_core.sv
dv/nlms_echo_canceller_with_freeze_core_tb.sv
